FILE: rtl/core/config_text_tokenizer_macros.svh
// ---------------------------------------------------------------------------
// config_text_tokenizer_macros
// Assertion helpers shared by the tokenizer checkers.
// ---------------------------------------------------------------------------
`ifndef CONFIG_TEXT_TOKENIZER_MACROS_SVH
`define CONFIG_TEXT_TOKENIZER_MACROS_SVH

// same-cycle implication, gated by reset
`define CTT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// next-cycle implication, gated by reset
`define CTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

`endif

FILE: rtl/core/ctt_pkg.sv
// ---------------------------------------------------------------------------
// ctt_pkg
// Types, codes and character helpers for the config text tokenizer.
// ---------------------------------------------------------------------------
package ctt_pkg;

  typedef enum logic [3:0] {
    M_IDLE, M_COMMENT, M_IDENT, M_NSIGN, M_NINT,
    M_NDOT, M_NFRAC, M_STR, M_ESC, M_ERROR
  } mode_t;

  typedef enum logic [2:0] {
    KW_EMPTY, KW_D, KW_DO, KW_E, KW_EN, KW_END, KW_NONE
  } kw_t;

  typedef enum logic [1:0] {
    REC_LEXEME, REC_TOKEN, REC_ERROR
  } rec_type_t;

  typedef enum logic [3:0] {
    TK_EOF, TK_IDENT, TK_DO, TK_END, TK_NUMBER, TK_STRING,
    TK_EQUAL, TK_COMMA, TK_DOT, TK_LBRACKET, TK_RBRACKET
  } tok_kind_t;

  typedef enum logic [2:0] {
    ERR_NONE, ERR_UNTERM, ERR_ESCAPE, ERR_QUOTE, ERR_UNEXPECTED, ERR_NUMBER
  } err_code_t;

  localparam logic [7:0] CH_EOT    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_EQUAL  = 8'h3d;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_LOW_D  = 8'h64;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_LOW_N  = 8'h6e;
  localparam logic [7:0] CH_LOW_O  = 8'h6f;
  localparam logic [7:0] CH_LOW_T  = 8'h74;

  localparam int QUEUE_DEPTH = 2;
  localparam int MAX_RECS    = 3;
  localparam int TDATA_BITS  = 64;

  typedef struct packed {
    rec_type_t   rtype;
    logic [7:0]  value;
    tok_kind_t   kind;
    logic [15:0] line;
    logic [15:0] column;
    logic [15:0] length;
    err_code_t   err;
  } rec_t;

  // all results caused by one text byte
  typedef struct packed {
    logic [1:0]             count;
    rec_t [MAX_RECS-1:0]    recs;
  } bundle_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic id_start(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a)) ||
           (c == CH_UNDER);
  endfunction

  function automatic logic id_char(input logic [7:0] c);
    return id_start(c) || is_digit(c);
  endfunction

  function automatic kw_t kw_next(input kw_t s, input logic [7:0] c);
    kw_t r;
    r = KW_NONE;
    if (s == KW_EMPTY && c == CH_LOW_D) r = KW_D;
    if (s == KW_D     && c == CH_LOW_O) r = KW_DO;
    if (s == KW_EMPTY && c == CH_LOW_E) r = KW_E;
    if (s == KW_E     && c == CH_LOW_N) r = KW_EN;
    if (s == KW_EN    && c == CH_LOW_D) r = KW_END;
    return r;
  endfunction

  function automatic tok_kind_t ident_kind(input kw_t s);
    tok_kind_t k;
    k = TK_IDENT;
    if (s == KW_DO)  k = TK_DO;
    if (s == KW_END) k = TK_END;
    return k;
  endfunction

  function automatic rec_t make_rec(input rec_type_t t, input logic [7:0] v,
                                    input tok_kind_t k, input logic [15:0] l,
                                    input logic [15:0] col, input logic [15:0] len,
                                    input err_code_t e);
    rec_t r;
    r.rtype  = t;
    r.value  = v;
    r.kind   = k;
    r.line   = l;
    r.column = col;
    r.length = len;
    r.err    = e;
    return r;
  endfunction

endpackage

FILE: rtl/core/config_text_tokenizer.sv
// ---------------------------------------------------------------------------
// config_text_tokenizer
// Streaming lexer for config text: bytes in, lexeme/token/error records out.
// ---------------------------------------------------------------------------
//  channel | dir | tdata                         | tuser       | tlast
//  in_     | in  | [7:0] text_byte               | -           | -
//  out_    | out | value, kind, line, column,    | record_type | last record
//          |     | length, error_code            |             | of the byte
//
// A text byte is taken every cycle while the 2-bundle queue has room; the
// lexer settles all of a byte's records (up to three) in the cycle it is taken.
// The out register sends one record per cycle while out_tready stays high;
// output bandwidth sets the sustained rate.
// Reset (synchronous, rst_n low) sets line and column to 1 and empties the queue.
// With out_tready low the out register, then the queue fill and in_tready drops.
// ---------------------------------------------------------------------------
module config_text_tokenizer import ctt_pkg::*; #(
  parameter int LINE_BITS   = 16,
  parameter int COLUMN_BITS = 16,
  parameter int LENGTH_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] text_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [7:0] value_byte, [11:8] token_kind, [27:12] line, [43:28] column,
  // [59:44] lexeme_length, [62:60] error_code, [63] zero
  output logic [TDATA_BITS-1:0] out_tdata,
  output logic [1:0]            out_tuser,  // [1:0] record_type
  output logic                  out_tlast   // last_of_run
);

  logic    q_full, q_push, q_pop, q_head_valid;
  bundle_t q_in, q_head;

  assign in_tready = !q_full;

  ctt_front #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (in_tvalid && in_tready),
    .text_byte (in_tdata),
    .push      (q_push),
    .bundle    (q_in)
  );

  ctt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  ctt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: rtl/core/ctt_front.sv
// ---------------------------------------------------------------------------
// ctt_front
// Lexer front end: classifies one taken byte a cycle and builds its bundle.
// ---------------------------------------------------------------------------
module ctt_front import ctt_pkg::*; #(
  parameter int LINE_BITS   = 16,
  parameter int COLUMN_BITS = 16,
  parameter int LENGTH_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] text_byte,
  output logic       push,
  output bundle_t    bundle
);

  mode_t                  mode_r, mode_nxt;
  kw_t                    kw_r, kw_nxt;
  logic [LINE_BITS-1:0]   cur_line_r, cur_line_nxt, start_line_r, start_line_nxt;
  logic [COLUMN_BITS-1:0] cur_col_r, cur_col_nxt, start_col_r, start_col_nxt;
  logic [LENGTH_BITS-1:0] tok_len_r, tok_len_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= M_IDLE;
      kw_r         <= KW_EMPTY;
      cur_line_r   <= LINE_BITS'(1);
      cur_col_r    <= COLUMN_BITS'(1);
      start_line_r <= LINE_BITS'(1);
      start_col_r  <= COLUMN_BITS'(1);
      tok_len_r    <= '0;
    end else if (take) begin
      mode_r       <= mode_nxt;
      kw_r         <= kw_nxt;
      cur_line_r   <= cur_line_nxt;
      cur_col_r    <= cur_col_nxt;
      start_line_r <= start_line_nxt;
      start_col_r  <= start_col_nxt;
      tok_len_r    <= tok_len_nxt;
    end
  end

  always_comb begin
    logic [1:0]  n;
    logic        do_idle;
    logic [7:0]  c;
    logic [7:0]  d;
    logic [15:0] cl16;
    logic [15:0] cc16;

    c              = text_byte;
    n              = 2'd0;
    do_idle        = 1'b0;
    d              = 8'h00;
    bundle         = '0;
    mode_nxt       = mode_r;
    kw_nxt         = kw_r;
    start_line_nxt = start_line_r;
    start_col_nxt  = start_col_r;
    tok_len_nxt    = tok_len_r;
    cur_line_nxt   = cur_line_r;
    cur_col_nxt    = cur_col_r;
    cl16           = 16'(cur_line_r);
    cc16           = 16'(cur_col_r);

    if (c == CH_EOT) begin
      unique case (mode_r)
        M_IDENT: begin
          bundle.recs[n] = make_rec(REC_TOKEN, 8'h00, ident_kind(kw_r), 16'(start_line_r),
                                    16'(start_col_r), 16'(tok_len_r), ERR_NONE);
          n = n + 2'd1;
        end
        M_NSIGN, M_NINT, M_NFRAC: begin
          bundle.recs[n] = make_rec(REC_TOKEN, 8'h00, TK_NUMBER, 16'(start_line_r),
                                    16'(start_col_r), 16'(tok_len_r), ERR_NONE);
          n = n + 2'd1;
        end
        M_NDOT: begin
          bundle.recs[n] = make_rec(REC_ERROR, 8'h00, TK_EOF, cl16, cc16, 16'h0000,
                                    ERR_NUMBER);
          n = n + 2'd1;
        end
        M_STR, M_ESC: begin
          bundle.recs[n] = make_rec(REC_ERROR, 8'h00, TK_EOF, 16'(start_line_r),
                                    16'(start_col_r), 16'h0000, ERR_UNTERM);
          n = n + 2'd1;
        end
        default: ;
      endcase
      bundle.recs[n] = make_rec(REC_TOKEN, 8'h00, TK_EOF, cl16, cc16, 16'h0000, ERR_NONE);
      n = n + 2'd1;
      // end of text: back to reset state
      mode_nxt       = M_IDLE;
      kw_nxt         = KW_EMPTY;
      cur_line_nxt   = LINE_BITS'(1);
      cur_col_nxt    = COLUMN_BITS'(1);
      start_line_nxt = LINE_BITS'(1);
      start_col_nxt  = COLUMN_BITS'(1);
      tok_len_nxt    = '0;
    end else begin
      unique case (mode_r)
        M_COMMENT: begin
          if (c == CH_LF) mode_nxt = M_IDLE;
        end
        M_IDENT: begin
          if (id_char(c)) begin
            kw_nxt = kw_next(kw_r, c);
            tok_len_nxt = (tok_len_nxt == '1) ? tok_len_nxt : tok_len_nxt + 1'b1;
            bundle.recs[n] = make_rec(REC_LEXEME, c, TK_EOF, 16'(start_line_nxt),
                                      16'(start_col_nxt), 16'h0000, ERR_NONE);
            n = n + 2'd1;
          end else begin
            bundle.recs[n] = make_rec(REC_TOKEN, 8'h00, ident_kind(kw_r),
                                      16'(start_line_r), 16'(start_col_r),
                                      16'(tok_len_r), ERR_NONE);
            n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_NSIGN, M_NINT, M_NFRAC: begin
          if (is_digit(c) || (c == CH_DOT && mode_r != M_NFRAC)) begin
            if (is_digit(c)) mode_nxt = (mode_r == M_NFRAC) ? M_NFRAC : M_NINT;
            else mode_nxt = M_NDOT;
            tok_len_nxt = (tok_len_nxt == '1) ? tok_len_nxt : tok_len_nxt + 1'b1;
            bundle.recs[n] = make_rec(REC_LEXEME, c, TK_EOF, 16'(start_line_nxt),
                                      16'(start_col_nxt), 16'h0000, ERR_NONE);
            n = n + 2'd1;
          end else begin
            bundle.recs[n] = make_rec(REC_TOKEN, 8'h00, TK_NUMBER, 16'(start_line_r),
                                      16'(start_col_r), 16'(tok_len_r), ERR_NONE);
            n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_NDOT: begin
          if (is_digit(c)) begin
            mode_nxt = M_NFRAC;
            tok_len_nxt = (tok_len_nxt == '1) ? tok_len_nxt : tok_len_nxt + 1'b1;
            bundle.recs[n] = make_rec(REC_LEXEME, c, TK_EOF, 16'(start_line_nxt),
                                      16'(start_col_nxt), 16'h0000, ERR_NONE);
            n = n + 2'd1;
          end else begin
            bundle.recs[n] = make_rec(REC_ERROR, 8'h00, TK_EOF, cl16, cc16, 16'h0000,
                                      ERR_NUMBER);
            n = n + 2'd1;
            mode_nxt = M_ERROR;
          end
        end
        M_STR: begin
          if (c == CH_DQUOTE) begin
            bundle.recs[n] = make_rec(REC_TOKEN, 8'h00, TK_STRING, 16'(start_line_r),
                                      16'(start_col_r), 16'(tok_len_r), ERR_NONE);
            n = n + 2'd1;
            mode_nxt = M_IDLE;
          end else if (c == CH_BSLASH) begin
            mode_nxt = M_ESC;
          end else begin
            tok_len_nxt = (tok_len_nxt == '1) ? tok_len_nxt : tok_len_nxt + 1'b1;
            bundle.recs[n] = make_rec(REC_LEXEME, c, TK_EOF, 16'(start_line_nxt),
                                      16'(start_col_nxt), 16'h0000, ERR_NONE);
            n = n + 2'd1;
          end
        end
        M_ESC: begin
          if (c == CH_DQUOTE || c == CH_BSLASH || c == CH_LOW_N || c == CH_LOW_T) begin
            if (c == CH_LOW_N) d = CH_LF;
            else if (c == CH_LOW_T) d = CH_TAB;
            else d = c;
            mode_nxt = M_STR;
            tok_len_nxt = (tok_len_nxt == '1) ? tok_len_nxt : tok_len_nxt + 1'b1;
            bundle.recs[n] = make_rec(REC_LEXEME, d, TK_EOF, 16'(start_line_nxt),
                                      16'(start_col_nxt), 16'h0000, ERR_NONE);
            n = n + 2'd1;
          end else begin
            bundle.recs[n] = make_rec(REC_ERROR, 8'h00, TK_EOF, cl16, cc16, 16'h0000,
                                      ERR_ESCAPE);
            n = n + 2'd1;
            mode_nxt = M_ERROR;
          end
        end
        M_ERROR: ;
        default: do_idle = 1'b1;
      endcase

      // the byte that ended a token, or any byte between tokens
      if (do_idle) begin
        mode_nxt = M_IDLE;
        if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
          mode_nxt = M_IDLE;
        end else if (c == CH_HASH) begin
          mode_nxt = M_COMMENT;
        end else if (c == CH_SQUOTE) begin
          bundle.recs[n] = make_rec(REC_ERROR, 8'h00, TK_EOF, cl16, cc16, 16'h0000,
                                    ERR_QUOTE);
          n = n + 2'd1;
          mode_nxt = M_ERROR;
        end else if (id_start(c) || c == CH_MINUS || is_digit(c) || c == CH_DQUOTE ||
                     c == CH_EQUAL || c == CH_COMMA || c == CH_DOT ||
                     c == CH_LBRACK || c == CH_RBRACK) begin
          start_line_nxt = cur_line_r;
          start_col_nxt  = cur_col_r;
          tok_len_nxt    = '0;
          if (id_start(c)) begin
            mode_nxt = M_IDENT;
            kw_nxt   = kw_next(KW_EMPTY, c);
          end else if (c == CH_MINUS) begin
            mode_nxt = M_NSIGN;
          end else if (is_digit(c)) begin
            mode_nxt = M_NINT;
          end else if (c == CH_DQUOTE) begin
            mode_nxt = M_STR;
          end
          if (c != CH_DQUOTE) begin
            tok_len_nxt = LENGTH_BITS'(1);
            bundle.recs[n] = make_rec(REC_LEXEME, c, TK_EOF, cl16, cc16, 16'h0000,
                                      ERR_NONE);
            n = n + 2'd1;
          end
          if (c == CH_EQUAL || c == CH_COMMA || c == CH_DOT || c == CH_LBRACK ||
              c == CH_RBRACK) begin
            bundle.recs[n] = make_rec(REC_TOKEN, 8'h00,
                                      (c == CH_EQUAL)  ? TK_EQUAL :
                                      (c == CH_COMMA)  ? TK_COMMA :
                                      (c == CH_DOT)    ? TK_DOT   :
                                      (c == CH_LBRACK) ? TK_LBRACKET : TK_RBRACKET,
                                      cl16, cc16, 16'h0001, ERR_NONE);
            n = n + 2'd1;
          end
        end else begin
          bundle.recs[n] = make_rec(REC_ERROR, 8'h00, TK_EOF, cl16, cc16, 16'h0000,
                                    ERR_UNEXPECTED);
          n = n + 2'd1;
          mode_nxt = M_ERROR;
        end
      end

      // position moves on after the byte is handled
      if (c == CH_LF) begin
        cur_line_nxt = (cur_line_r == '1) ? cur_line_r : cur_line_r + 1'b1;
        cur_col_nxt  = COLUMN_BITS'(1);
      end else begin
        cur_col_nxt  = (cur_col_r == '1) ? cur_col_r : cur_col_r + 1'b1;
      end
    end

    bundle.count = n;
  end

  assign push = take && (bundle.count != 2'd0);

endmodule

FILE: rtl/core/ctt_queue.sv
// ---------------------------------------------------------------------------
// ctt_queue
// Short bundle FIFO between the lexer front end and the output serializer.
// ---------------------------------------------------------------------------
module ctt_queue import ctt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t push_data,
  output logic    full,
  input  logic    pop,
  output logic    head_valid,
  output bundle_t head
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  bundle_t               mem_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_BITS-1:0]   cnt_r;

  assign full       = (cnt_r == CNT_BITS'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

FILE: rtl/core/ctt_back.sv
// ---------------------------------------------------------------------------
// ctt_back
// Serializer: walks each bundle one record a cycle into out_rec_r unless stalled.
// ---------------------------------------------------------------------------
module ctt_back import ctt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  head_valid,
  input  bundle_t               head,
  output logic                  pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [TDATA_BITS-1:0] out_tdata,
  output logic [1:0]            out_tuser,
  output logic                  out_tlast
);

  logic       out_valid_r;
  rec_t       out_rec_r;
  logic       out_last_r;
  logic [1:0] idx_r, idx_nxt;
  logic       load, last;

  assign load = head_valid && (!out_valid_r || out_tready);
  assign last = (idx_r == head.count - 2'd1);
  assign pop  = load && last;

  always_comb begin
    idx_nxt = idx_r;
    if (load) idx_nxt = last ? 2'd0 : idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
      if (load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_rec_r  <= head.recs[idx_r];
      out_last_r <= last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_rec_r.rtype;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, out_rec_r.err, out_rec_r.length, out_rec_r.column,
                       out_rec_r.line, out_rec_r.kind, out_rec_r.value};

endmodule

FILE: rtl/core/ctt_checker.sv
// ---------------------------------------------------------------------------
// ctt_checker
// Port-level checks on the tokenizer output stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "config_text_tokenizer_macros.svh"

module ctt_checker import ctt_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [TDATA_BITS-1:0] out_tdata,
  input logic [1:0]            out_tuser,
  input logic                  out_tlast
);

  // a stalled word holds
  `CTT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  // EOF token always closes the records of its byte
  `CTT_ASSERT_IMPLY(a_eof_last, clk, rst_n, out_tvalid && out_tuser == REC_TOKEN && out_tdata[11:8] == TK_EOF, out_tlast)

  // error records carry only position and code
  `CTT_ASSERT_IMPLY(a_err_clean, clk, rst_n, out_tvalid && out_tuser == REC_ERROR, out_tdata[11:0] == 12'h000 && out_tdata[59:44] == 16'h0000 && out_tdata[62:60] != ERR_NONE)

  // lexeme bytes carry no length or code, and no record type beyond error
  `CTT_ASSERT_IMPLY(a_lex_clean, clk, rst_n, out_tvalid, out_tuser != 2'd3 && (out_tuser != REC_LEXEME || (out_tdata[59:44] == 16'h0000 && out_tdata[62:60] == ERR_NONE)))

endmodule

bind config_text_tokenizer ctt_checker u_ctt_checker (.*);

FILE: test/config_text_tokenizer_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// config_text_tokenizer_tb
// Streams config text into the tokenizer, one byte per word, and checks every
// output record against a local tokenizer model: directed texts for each
// token kind and error, and random config texts under random stalls on both
// sides.
// ---------------------------------------------------------------------------
module config_text_tokenizer_tb;
  import ctt_pkg::*;

  localparam int    SPAN_MAX  = 11;
  localparam string ID_FIRST  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  localparam string ID_ALL    =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

  typedef struct packed {
    rec_type_t   rtype;
    logic [7:0]  value;
    tok_kind_t   kind;
    logic [15:0] line;
    logic [15:0] column;
    logic [15:0] length;
    err_code_t   err;
    logic        last;
  } tok_rec_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = 8'h00;
  logic                  out_tvalid;
  logic                  out_tready = 1'b1;
  logic [TDATA_BITS-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;

  // lexer state mirrored by the model
  mode_t       lx_mode;
  kw_t         kw;
  logic [15:0] pos_line, pos_col, tok_line, tok_col, tok_len;

  tok_rec_t    step_recs[$];
  tok_rec_t    pending_records[$];
  tok_rec_t    want;
  logic [7:0]  text_buf[$];

  int unsigned sink_hold = 0;
  int unsigned sink_pause;
  int unsigned bytes_sent = 0;
  int unsigned records_checked = 0;
  int unsigned mismatches = 0;

  config_text_tokenizer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #4 clk = ~clk;

  // ---------------- tokenizer model ----------------

  function automatic logic [15:0] sat16(input logic [15:0] v);
    return (v == 16'hffff) ? v : v + 16'd1;
  endfunction

  function automatic logic ch_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic ch_word_start(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
  endfunction

  function automatic logic ch_word(input logic [7:0] c);
    return ch_word_start(c) || ch_digit(c);
  endfunction

  // prefix tracker for the two keywords
  function automatic kw_t kw_step(input kw_t s, input logic [7:0] c);
    case (s)
      KW_EMPTY: return (c == CH_LOW_D) ? KW_D : (c == CH_LOW_E) ? KW_E : KW_NONE;
      KW_D:     return (c == CH_LOW_O) ? KW_DO : KW_NONE;
      KW_E:     return (c == CH_LOW_N) ? KW_EN : KW_NONE;
      KW_EN:    return (c == CH_LOW_D) ? KW_END : KW_NONE;
      default:  return KW_NONE;
    endcase
  endfunction

  function automatic tok_kind_t word_kind();
    if (kw == KW_DO) return TK_DO;
    if (kw == KW_END) return TK_END;
    return TK_IDENT;
  endfunction

  function automatic void emit(input rec_type_t t, input logic [7:0] v,
                               input tok_kind_t k, input logic [15:0] l,
                               input logic [15:0] c, input logic [15:0] len,
                               input err_code_t e);
    tok_rec_t r;
    r.rtype  = t;
    r.value  = v;
    r.kind   = k;
    r.line   = l;
    r.column = c;
    r.length = len;
    r.err    = e;
    r.last   = 1'b0;
    step_recs.push_back(r);
  endfunction

  function automatic void lexer_reset();
    lx_mode  = M_IDLE;
    kw       = KW_EMPTY;
    pos_line = 16'd1;
    pos_col  = 16'd1;
    tok_line = 16'd1;
    tok_col  = 16'd1;
    tok_len  = 16'd0;
  endfunction

  function automatic void begin_token(input mode_t m);
    tok_line = pos_line;
    tok_col  = pos_col;
    tok_len  = 16'd0;
    lx_mode  = m;
  endfunction

  function automatic void add_lexeme(input logic [7:0] b);
    tok_len = sat16(tok_len);
    emit(REC_LEXEME, b, TK_EOF, tok_line, tok_col, 16'd0, ERR_NONE);
  endfunction

  function automatic void close_token(input tok_kind_t k);
    emit(REC_TOKEN, 8'h00, k, tok_line, tok_col, tok_len, ERR_NONE);
    lx_mode = M_IDLE;
  endfunction

  function automatic void raise_error(input err_code_t e, input logic [15:0] l,
                                      input logic [15:0] c);
    emit(REC_ERROR, 8'h00, TK_EOF, l, c, 16'd0, e);
    lx_mode = M_ERROR;
  endfunction

  function automatic void one_char(input logic [7:0] c, input tok_kind_t k);
    begin_token(M_IDLE);
    add_lexeme(c);
    close_token(k);
  endfunction

  // byte seen between tokens (also the delimiter that ended a token)
  function automatic void lex_fresh(input logic [7:0] c);
    lx_mode = M_IDLE;
    if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
    end else if (c == CH_HASH) begin
      lx_mode = M_COMMENT;
    end else if (ch_word_start(c)) begin
      begin_token(M_IDENT);
      kw = kw_step(KW_EMPTY, c);
      add_lexeme(c);
    end else if (c == CH_MINUS) begin
      begin_token(M_NSIGN);
      add_lexeme(c);
    end else if (ch_digit(c)) begin
      begin_token(M_NINT);
      add_lexeme(c);
    end else if (c == CH_DQUOTE) begin
      begin_token(M_STR);
    end else if (c == CH_SQUOTE) begin
      raise_error(ERR_QUOTE, pos_line, pos_col);
    end else if (c == CH_EQUAL) begin
      one_char(c, TK_EQUAL);
    end else if (c == CH_COMMA) begin
      one_char(c, TK_COMMA);
    end else if (c == CH_DOT) begin
      one_char(c, TK_DOT);
    end else if (c == CH_LBRACK) begin
      one_char(c, TK_LBRACKET);
    end else if (c == CH_RBRACK) begin
      one_char(c, TK_RBRACKET);
    end else begin
      raise_error(ERR_UNEXPECTED, pos_line, pos_col);
    end
  endfunction

  // all records caused by one text byte, appended to pending_records
  function automatic void tokenize_byte(input logic [7:0] c);
    step_recs.delete();
    if (c == CH_EOT) begin
      case (lx_mode)
        M_IDENT:                close_token(word_kind());
        M_NSIGN, M_NINT, M_NFRAC: close_token(TK_NUMBER);
        M_NDOT:                 raise_error(ERR_NUMBER, pos_line, pos_col);
        M_STR, M_ESC:           raise_error(ERR_UNTERM, tok_line, tok_col);
        default: ;
      endcase
      emit(REC_TOKEN, 8'h00, TK_EOF, pos_line, pos_col, 16'd0, ERR_NONE);
      lexer_reset();
    end else begin
      case (lx_mode)
        M_COMMENT: begin
          if (c == CH_LF) lx_mode = M_IDLE;
        end
        M_IDENT: begin
          if (ch_word(c)) begin
            kw = kw_step(kw, c);
            add_lexeme(c);
          end else begin
            close_token(word_kind());
            lex_fresh(c);
          end
        end
        M_NSIGN, M_NINT: begin
          if (ch_digit(c)) begin
            lx_mode = M_NINT;
            add_lexeme(c);
          end else if (c == CH_DOT) begin
            lx_mode = M_NDOT;
            add_lexeme(c);
          end else begin
            close_token(TK_NUMBER);
            lex_fresh(c);
          end
        end
        M_NDOT: begin
          if (ch_digit(c)) begin
            lx_mode = M_NFRAC;
            add_lexeme(c);
          end else begin
            raise_error(ERR_NUMBER, pos_line, pos_col);
          end
        end
        M_NFRAC: begin
          if (ch_digit(c)) begin
            add_lexeme(c);
          end else begin
            close_token(TK_NUMBER);
            lex_fresh(c);
          end
        end
        M_STR: begin
          if (c == CH_DQUOTE) close_token(TK_STRING);
          else if (c == CH_BSLASH) lx_mode = M_ESC;
          else add_lexeme(c);
        end
        M_ESC: begin
          if (c == CH_DQUOTE || c == CH_BSLASH) begin
            lx_mode = M_STR;
            add_lexeme(c);
          end else if (c == CH_LOW_N) begin
            lx_mode = M_STR;
            add_lexeme(CH_LF);
          end else if (c == CH_LOW_T) begin
            lx_mode = M_STR;
            add_lexeme(CH_TAB);
          end else begin
            raise_error(ERR_ESCAPE, pos_line, pos_col);
          end
        end
        M_ERROR: ;
        default: lex_fresh(c);
      endcase
      if (c == CH_LF) begin
        pos_line = sat16(pos_line);
        pos_col  = 16'd1;
      end else begin
        pos_col = sat16(pos_col);
      end
    end
    if (step_recs.size() != 0) step_recs[step_recs.size()-1].last = 1'b1;
    foreach (step_recs[i]) pending_records.push_back(step_recs[i]);
  endfunction

  // ---------------- result side ----------------

  function automatic void check_field(input string name, input longint unsigned want_v,
                                      input longint unsigned got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endfunction

  // receiver stall: drawn after each word taken
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b1;
      sink_hold  <= 0;
    end else if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
      if (sink_hold == 1) out_tready <= 1'b1;
    end else if (out_tvalid && out_tready) begin
      sink_pause = $urandom_range(0, SPAN_MAX);
      if (sink_pause != 0) begin
        out_tready <= 1'b0;
        sink_hold  <= sink_pause;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_records.size() == 0) begin
        $error("record with nothing pending: tuser %0d tdata %h", out_tuser, out_tdata);
        mismatches++;
      end else begin
        want = pending_records.pop_front();
        check_field("record_type",   want.rtype,  out_tuser);
        check_field("value_byte",    want.value,  out_tdata[7:0]);
        check_field("token_kind",    want.kind,   out_tdata[11:8]);
        check_field("line",          want.line,   out_tdata[27:12]);
        check_field("column",        want.column, out_tdata[43:28]);
        check_field("lexeme_length", want.length, out_tdata[59:44]);
        check_field("error_code",    want.err,    out_tdata[62:60]);
        check_field("last_of_run",   want.last,   out_tlast);
        records_checked++;
      end
    end
  end

  // ---------------- stimulus ----------------

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = $urandom_range(0, SPAN_MAX);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    tokenize_byte(b);
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic void push_str(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endfunction

  // any nonzero byte that does not close or escape a string
  function automatic logic [7:0] string_char();
    logic [7:0] ch;
    do ch = 8'($urandom_range(1, 255)); while (ch == CH_DQUOTE || ch == CH_BSLASH);
    return ch;
  endfunction

  // any nonzero byte that stays inside a comment
  function automatic logic [7:0] comment_char();
    logic [7:0] ch;
    do ch = 8'($urandom_range(1, 255)); while (ch == CH_LF);
    return ch;
  endfunction

  function automatic void add_random_piece();
    int unsigned n;
    case ($urandom_range(0, 15))
      0, 1, 2: begin
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 3))
            0: push_str("do");
            1: push_str("end");
            2: push_str("d");
            default: push_str("en");
          endcase
        end else begin
          text_buf.push_back(pick(ID_FIRST));
          n = $urandom_range(0, 5);
          repeat (n) text_buf.push_back(pick(ID_ALL));
        end
      end
      3, 4: begin
        if ($urandom_range(0, 1) == 0) begin
          text_buf.push_back(CH_MINUS);
          n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
        end else begin
          n = $urandom_range(1, 4);
        end
        repeat (n) text_buf.push_back(pick("0123456789"));
        if (n != 0 && $urandom_range(0, 1) == 0) begin
          text_buf.push_back(CH_DOT);
          n = $urandom_range(1, 3);
          repeat (n) text_buf.push_back(pick("0123456789"));
        end
      end
      5, 6: begin
        text_buf.push_back(CH_DQUOTE);
        n = $urandom_range(0, 6);
        repeat (n) begin
          if ($urandom_range(0, 3) == 0) begin
            text_buf.push_back(CH_BSLASH);
            text_buf.push_back(pick("\"\\nt"));
          end else begin
            text_buf.push_back(string_char());
          end
        end
        text_buf.push_back(CH_DQUOTE);
      end
      7, 8, 9: text_buf.push_back(pick("=,.[]"));
      10: begin
        n = $urandom_range(1, 3);
        repeat (n) text_buf.push_back($urandom_range(0, 3) == 0 ? CH_CR : pick(" \t\n"));
      end
      11: begin
        text_buf.push_back(CH_HASH);
        n = $urandom_range(0, 5);
        repeat (n) text_buf.push_back(comment_char());
        text_buf.push_back(CH_LF);
      end
      default: begin
        // noise and broken constructs
        case ($urandom_range(0, 4))
          0: text_buf.push_back(8'($urandom_range(1, 255)));
          1: text_buf.push_back(CH_SQUOTE);
          2: begin
            push_str("\"a\\");
            text_buf.push_back(pick("xq0 \"n"));
          end
          3: begin
            push_str("3.");
            text_buf.push_back(pick("a =5"));
          end
          default: begin
            text_buf.push_back(CH_DQUOTE);
            text_buf.push_back(string_char());
          end
        endcase
      end
    endcase
  endfunction

  task automatic send_random_text();
    int unsigned pieces;
    pieces = $urandom_range(3, 12);
    text_buf.delete();
    repeat (pieces) begin
      add_random_piece();
      if ($urandom_range(0, 2) == 0) text_buf.push_back(pick(" \t\n"));
    end
    foreach (text_buf[i]) send_byte(text_buf[i]);
    send_byte(CH_EOT);
  endtask

  // ---------------- tests ----------------

  task automatic test_tokens();
    send_text("do end dox x=,.[]#c");
    send_byte(CH_LF);
    send_text("e_9\t_Z");
    send_byte(CH_CR);
    send_byte(CH_EOT);
  endtask

  task automatic test_numbers();
    send_text("-5.25 - 7,0.");
    send_byte(CH_LF);            // bad number at the newline
    send_text("x");              // dropped, error still pending
    send_byte(CH_EOT);
    send_text("42");
    send_byte(CH_EOT);
    send_text("9.");
    send_byte(CH_EOT);
    send_text("-");
    send_byte(CH_EOT);
  endtask

  task automatic test_strings();
    send_text("\"a\\\"\\\\\\n\\tb\"\"\"");
    send_byte(CH_EOT);
    send_text("\"x\\q=\"");
    send_byte(CH_EOT);
    send_text("\"abc");
    send_byte(CH_EOT);
    send_text("\"\\");
    send_byte(CH_EOT);
  endtask

  task automatic test_bad_chars();
    send_byte(CH_EOT);
    send_text("'");
    send_byte(CH_EOT);
    send_byte(8'hff);
    send_byte(CH_EOT);
    send_byte(8'h80);
    send_byte(CH_EOT);
    send_text("a@");
    send_byte(CH_EOT);
  endtask

  task automatic test_random_text();
    int unsigned first;
    first = bytes_sent;
    while (bytes_sent - first < 115) send_random_text();
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    for (int i = 0; i < 20000 && pending_records.size() != 0; i++) @(posedge clk);
    repeat (16) @(posedge clk);
    if (pending_records.size() != 0) begin
      $error("%0d records never arrived", pending_records.size());
      mismatches++;
    end
  endtask

  initial begin
    lexer_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_tokens();
    test_numbers();
    test_strings();
    test_bad_chars();
    test_random_text();
    drain();
    $display("Run covered %0d text bytes and %0d output records,", bytes_sent,
             records_checked);
    $display("directed tokens and errors, random texts under random stalls.");
    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
